// ===== hw/rtl/fixed_point_radix2_fft_unit_macros.svh =====
// Shared assertion macros for the FFT unit.
`ifndef FIXED_POINT_RADIX2_FFT_UNIT_MACROS_SVH
`define FIXED_POINT_RADIX2_FFT_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FFTU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FFTU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/fftu_pkg.sv =====
package fftu_pkg;

    localparam int N_POINTS = 256;
    localparam int LOG2N    = $clog2(N_POINTS);
    localparam int ADDR_W   = LOG2N;
    localparam int STAGE_W  = $clog2(LOG2N);
    localparam int HALF     = N_POINTS / 2;
    localparam int QUARTER  = N_POINTS / 4;
    localparam int SAMPLE_W = 16;
    localparam int ENTRY_W  = 2 * SAMPLE_W;
    localparam int OP_W     = 2;
    localparam int INDEX_W  = 8;

    localparam longint unsigned PI_Q30 = 64'd3373259426;

    // Taylor series divisors (2i)(2i+1) for i = 1..12
    localparam longint unsigned SIN_DIV [1:12] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
    };

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OP_W-1:0] OP_RUN  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef sample_t twid_tab_t [0:HALF-1];

    // Port request from a sample store client; entry is {real, imag}
    typedef struct packed {
        logic                we;
        logic [ADDR_W-1:0]   waddr;
        logic [ENTRY_W-1:0]  wdata;
        logic [ADDR_W-1:0]   raddr;
    } ram_req_t;

    // Rounded Q15 magnitude of sin(2*pi*m/N) for the first quadrant
    function automatic int quarter_sin(input int unsigned m);
        longint unsigned x;
        longint unsigned term;
        longint          sum;
        x    = (PI_Q30 * 64'd2 * longint'(m)) / N_POINTS;
        term = x;
        sum  = longint'(x);
        for (int unsigned i = 1; i <= 12; i++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / SIN_DIV[i];
            if (i[0]) sum = sum - longint'(term);
            else      sum = sum + longint'(term);
        end
        if (sum < 0) sum = 0;
        sum = (sum + 16384) / 32768;
        if (sum > 32768) sum = 32768;
        return int'(sum);
    endfunction

    function automatic sample_t full_sin(input int unsigned k);
        int unsigned kk;
        int unsigned quad;
        int unsigned r;
        int          v;
        kk   = k % N_POINTS;
        quad = kk / QUARTER;
        r    = kk % QUARTER;
        if (quad[0]) v = quarter_sin(QUARTER - r);
        else         v = quarter_sin(r);
        if (quad >= 2) v = -v;
        if (v > 32767)  v = 32767;
        if (v < -32768) v = -32768;
        return sample_t'(v);
    endfunction

    function automatic twid_tab_t build_twid(input logic want_cos);
        twid_tab_t t;
        for (int unsigned k = 0; k < HALF; k++) begin
            t[k] = full_sin(want_cos ? k + QUARTER : k);
        end
        return t;
    endfunction

    localparam twid_tab_t TWID_COS = build_twid(1'b1);
    localparam twid_tab_t TWID_SIN = build_twid(1'b0);

endpackage

// ===== hw/rtl/fixed_point_radix2_fft_unit.sv =====
// Channel  Handshake                 Payload
// in       in_valid / in_stall       operation, bin_index, sample_real, sample_imag, inverse
// out      out_valid / out_stall     bin_real, bin_imag
//
// Run: its length is set by one shared multiplier and the single read and write port
// of the sample store; the reorder pass makes S swaps, 120 at N=256.
// Reset is asynchronous, active low; sample store contents are undefined until loaded.
// A finished result waits in the output register; the next item is taken meanwhile,
// and the block holds that item's result until out_stall drops.
`include "fixed_point_radix2_fft_unit_macros.svh"

module fixed_point_radix2_fft_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [fftu_pkg::OP_W-1:0]         operation,
    input  logic [fftu_pkg::INDEX_W-1:0]      bin_index,
    input  logic signed [15:0]                sample_real,
    input  logic signed [15:0]                sample_imag,
    input  logic                              inverse,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [15:0]                bin_real,
    output logic signed [15:0]                bin_imag
);

    localparam logic [2:0] T_IDLE = 3'd0;
    localparam logic [2:0] T_EXEC = 3'd1;
    localparam logic [2:0] T_RDW  = 3'd2;
    localparam logic [2:0] T_RUN  = 3'd3;
    localparam logic [2:0] T_FIN  = 3'd4;

    localparam int AW = fftu_pkg::ADDR_W;
    localparam int SW16 = fftu_pkg::SAMPLE_W;

    logic [2:0]                   state_reg, state_next;
    logic [fftu_pkg::OP_W-1:0]    op_reg;
    logic [AW-1:0]                idx_reg;
    fftu_pkg::sample_t            ld_re_reg, ld_im_reg;
    logic                         inv_reg;
    fftu_pkg::sample_t            res_re_reg, res_im_reg;
    logic                         out_valid_reg;
    fftu_pkg::sample_t            bin_real_reg, bin_imag_reg;

    logic                         in_xfer;
    logic                         slot_free;
    logic                         eng_start;
    logic                         eng_done;
    fftu_pkg::ram_req_t           eng_req, top_req, ram_req;
    logic [fftu_pkg::ENTRY_W-1:0] rdata;

    assign in_stall  = (state_reg != T_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign eng_start = (state_reg == T_EXEC) && (op_reg == fftu_pkg::OP_RUN);

    // Item sequencing
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            T_IDLE: if (in_xfer) state_next = T_EXEC;
            T_EXEC:
            begin
                priority if (op_reg == fftu_pkg::OP_READ) state_next = T_RDW;
                else if (op_reg == fftu_pkg::OP_RUN)      state_next = T_RUN;
                else                                      state_next = T_FIN;
            end
            T_RDW:  state_next = T_FIN;
            T_RUN:  if (eng_done) state_next = T_FIN;
            T_FIN:  if (slot_free) state_next = T_IDLE;
            default: state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == T_FIN && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the item and the result
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg    <= operation;
            idx_reg   <= bin_index[AW-1:0];
            ld_re_reg <= sample_real;
            ld_im_reg <= sample_imag;
            inv_reg   <= inverse;
        end
        if (state_reg == T_EXEC)
        begin
            res_re_reg <= '0;
            res_im_reg <= '0;
        end
        else if (state_reg == T_RDW)
        begin
            res_re_reg <= rdata[fftu_pkg::ENTRY_W-1:SW16];
            res_im_reg <= rdata[SW16-1:0];
        end
        if (state_reg == T_FIN && slot_free)
        begin
            bin_real_reg <= res_re_reg;
            bin_imag_reg <= res_im_reg;
        end
    end

    // Store port: engine owns it during a run
    always_comb
    begin
        top_req.we    = (state_reg == T_EXEC) && (op_reg == fftu_pkg::OP_LOAD);
        top_req.waddr = idx_reg;
        top_req.wdata = {ld_re_reg, ld_im_reg};
        top_req.raddr = idx_reg;
        ram_req       = (state_reg == T_RUN) ? eng_req : top_req;
    end

    fftu_ram #(
        .WIDTH (fftu_pkg::ENTRY_W),
        .DEPTH (fftu_pkg::N_POINTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (rdata)
    );

    fftu_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (eng_start),
        .inverse (inv_reg),
        .rdata   (rdata),
        .req     (eng_req),
        .done    (eng_done)
    );

    assign out_valid = out_valid_reg;
    assign bin_real  = bin_real_reg;
    assign bin_imag  = bin_imag_reg;

    `FFTU_ASSERT_NOW(a_done_in_run, eng_done, (state_reg == T_RUN), "engine done outside run")
    `FFTU_ASSERT_NEXT(a_xfer_exec, in_xfer, (state_reg == T_EXEC), "item not executed")
    `FFTU_ASSERT_NOW(a_zero_result, (state_reg == T_FIN && op_reg != fftu_pkg::OP_READ), (res_re_reg == '0 && res_im_reg == '0), "nonzero result for non-read")

endmodule

// ===== hw/rtl/fftu_ram.sv =====
module fftu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry, read one entry with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/fftu_engine.sv =====
`include "fixed_point_radix2_fft_unit_macros.svh"

module fftu_engine (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               inverse,
    input  logic [fftu_pkg::ENTRY_W-1:0]       rdata,
    output fftu_pkg::ram_req_t                 req,
    output logic                               done
);

    localparam logic [3:0] E_IDLE   = 4'd0;
    localparam logic [3:0] E_BR_CHK = 4'd1;
    localparam logic [3:0] E_RD_J   = 4'd2;
    localparam logic [3:0] E_RD_I   = 4'd3;
    localparam logic [3:0] E_M0     = 4'd4;
    localparam logic [3:0] E_M1     = 4'd5;
    localparam logic [3:0] E_M2     = 4'd6;
    localparam logic [3:0] E_M3     = 4'd7;
    localparam logic [3:0] E_M4     = 4'd8;
    localparam logic [3:0] E_W_J    = 4'd9;
    localparam logic [3:0] E_W_I    = 4'd10;
    localparam logic [3:0] E_NEXT   = 4'd11;

    localparam int AW = fftu_pkg::ADDR_W;
    localparam int SW = fftu_pkg::STAGE_W;

    logic [3:0]              state_reg, state_next;
    logic                    bfly_reg, bfly_next;
    logic [AW-1:0]           cnt_reg, cnt_next;
    logic [SW-1:0]           stage_reg, stage_next;
    logic                    inv_reg;
    logic                    done_reg, done_next;

    logic [fftu_pkg::ENTRY_W-1:0] xi_reg, xj_reg;
    fftu_pkg::sample_t       w_re_reg, w_im_reg;
    logic signed [30:0]      prod_reg;
    logic signed [31:0]      acc_reg, tr_reg, ti_reg;

    logic [AW-1:0]           rev_addr, bf_i, bf_j, i_addr, j_addr;
    logic [AW-1:0]           b_ext;
    logic [AW-2:0]           k_idx;
    logic [SW-1:0]           k_shift;
    fftu_pkg::sample_t       wi_raw, wi_eff;
    fftu_pkg::sample_t       mul_a, mul_b;
    logic signed [31:0]      prod;
    logic signed [30:0]      prod_half;

    // Round (x * 2^15 +/- t) back to 16 bits with saturation
    function automatic logic signed [33:0] sat32(input logic signed [33:0] v);
        if (v > 34'sh07FFFFFFF)      return 34'sh07FFFFFFF;
        else if (v < 34'sh380000000) return 34'sh380000000;
        else                         return v;
    endfunction

    function automatic fftu_pkg::sample_t round_sum(input fftu_pkg::sample_t x,
                                                    input logic signed [31:0] t,
                                                    input logic sub);
        logic signed [33:0] a;
        logic signed [33:0] te;
        logic signed [33:0] s;
        a  = {{3{x[15]}}, x, 15'b0};
        te = {{2{t[31]}}, t};
        s  = sat32(sub ? a - te : a + te);
        s  = sat32(s + 34'sd32768);
        return s[31:16];
    endfunction

    // Bit-reversed index for the reorder pass
    always_comb
    begin
        for (int p = 0; p < AW; p++)
        begin
            rev_addr[p] = cnt_reg[AW-1-p];
        end
    end

    // Butterfly pair: insert a zero (i) or one (j) at bit position stage
    always_comb
    begin
        b_ext = {1'b0, cnt_reg[AW-2:0]};
        for (int p = 0; p < AW; p++)
        begin
            if (p < int'(stage_reg))
            begin
                bf_i[p] = b_ext[p];
            end
            else if (p == int'(stage_reg))
            begin
                bf_i[p] = 1'b0;
            end
            else
            begin
                bf_i[p] = b_ext[(p > 0) ? p - 1 : 0];
            end
        end
        bf_j = bf_i | (AW'(1) << stage_reg);
    end

    assign i_addr = bfly_reg ? bf_i : cnt_reg;
    assign j_addr = bfly_reg ? bf_j : rev_addr;

    // Twiddle index m * N/len
    assign k_shift = SW'(fftu_pkg::LOG2N - 1) - stage_reg;
    assign k_idx   = cnt_reg[AW-2:0] << k_shift;
    assign wi_raw  = fftu_pkg::TWID_SIN[k_idx];
    assign wi_eff  = !inv_reg ? wi_raw :
                     (wi_raw == 16'sh8000) ? 16'sh7FFF : -wi_raw;

    // Shared multiplier, one product per cycle
    assign mul_a = (state_reg == E_M0 || state_reg == E_M2) ? w_re_reg : w_im_reg;
    assign mul_b = (state_reg == E_M1 || state_reg == E_M2) ?
                   xj_reg[fftu_pkg::SAMPLE_W-1:0] :
                   xj_reg[fftu_pkg::ENTRY_W-1:fftu_pkg::SAMPLE_W];
    assign prod      = mul_a * mul_b;
    assign prod_half = (prod == 32'sh40000000) ? 31'sh3FFFFFFF : prod[30:0];

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        bfly_next  = bfly_reg;
        cnt_next   = cnt_reg;
        stage_next = stage_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            E_IDLE:
            begin
                if (start)
                begin
                    bfly_next  = 1'b0;
                    cnt_next   = '0;
                    stage_next = '0;
                    state_next = E_BR_CHK;
                end
            end
            E_BR_CHK: state_next = (rev_addr > cnt_reg) ? E_RD_J : E_NEXT;
            E_RD_J:   state_next = E_RD_I;
            E_RD_I:   state_next = E_M0;
            E_M0:     state_next = bfly_reg ? E_M1 : E_W_J;
            E_M1:     state_next = E_M2;
            E_M2:     state_next = E_M3;
            E_M3:     state_next = E_M4;
            E_M4:     state_next = E_W_J;
            E_W_J:    state_next = E_W_I;
            E_W_I:    state_next = E_NEXT;
            E_NEXT:
            begin
                if (!bfly_reg)
                begin
                    if (cnt_reg == AW'(fftu_pkg::N_POINTS - 1))
                    begin
                        bfly_next  = 1'b1;
                        cnt_next   = '0;
                        state_next = E_RD_J;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + AW'(1);
                        state_next = E_BR_CHK;
                    end
                end
                else if (&cnt_reg[AW-2:0])
                begin
                    cnt_next = '0;
                    if (stage_reg == SW'(fftu_pkg::LOG2N - 1))
                    begin
                        done_next  = 1'b1;
                        state_next = E_IDLE;
                    end
                    else
                    begin
                        stage_next = stage_reg + SW'(1);
                        state_next = E_RD_J;
                    end
                end
                else
                begin
                    cnt_next   = cnt_reg + AW'(1);
                    state_next = E_RD_J;
                end
            end
            default: state_next = E_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            bfly_reg  <= 1'b0;
            cnt_reg   <= '0;
            stage_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            bfly_reg  <= bfly_next;
            cnt_reg   <= cnt_next;
            stage_reg <= stage_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == E_IDLE && start)
        begin
            inv_reg <= inverse;
        end
        if (state_reg == E_RD_J)
        begin
            w_re_reg <= fftu_pkg::TWID_COS[k_idx];
            w_im_reg <= wi_eff;
        end
        if (state_reg == E_RD_I)
        begin
            xj_reg <= rdata;
        end
        if (state_reg == E_M0)
        begin
            xi_reg <= rdata;
        end
        prod_reg <= prod_half;
        if (state_reg == E_M1 || state_reg == E_M3)
        begin
            acc_reg <= {prod_reg[30], prod_reg};
        end
        if (state_reg == E_M2)
        begin
            tr_reg <= acc_reg - {prod_reg[30], prod_reg};
        end
        if (state_reg == E_M4)
        begin
            ti_reg <= acc_reg + {prod_reg[30], prod_reg};
        end
    end

    // Store port
    always_comb
    begin
        req.we    = (state_reg == E_W_J) || (state_reg == E_W_I);
        req.raddr = (state_reg == E_RD_J) ? j_addr : i_addr;
        req.waddr = (state_reg == E_W_J) ? j_addr : i_addr;
        if (!bfly_reg)
        begin
            req.wdata = (state_reg == E_W_J) ? xi_reg : xj_reg;
        end
        else
        begin
            req.wdata = {round_sum(xi_reg[fftu_pkg::ENTRY_W-1:fftu_pkg::SAMPLE_W],
                                   tr_reg, state_reg == E_W_J),
                         round_sum(xi_reg[fftu_pkg::SAMPLE_W-1:0],
                                   ti_reg, state_reg == E_W_J)};
        end
    end

    assign done = done_reg;

    `FFTU_ASSERT_NOW(a_we_state, req.we, (state_reg == E_W_J || state_reg == E_W_I), "write outside write step")
    `FFTU_ASSERT_NOW(a_pair_order, (state_reg == E_W_J), (j_addr > i_addr), "pair order broken")
    `FFTU_ASSERT_NOW(a_done_idle, done_reg, (state_reg == E_IDLE), "done while busy")

endmodule
